>>> rtl/core/dawv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder package
// Shared codes, constants, controller/datapath structs and the month table.
// ----------------------------------------------------------------------------
package dawv_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam logic [1:0] OP_DAYS  = 2'd0;
   localparam logic [1:0] OP_WEEKS = 2'd1;
   localparam logic [1:0] OP_YEARS = 2'd2;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BAD_DATE = 2'd1;
   localparam logic [1:0] STAT_OVERFLOW = 2'd2;

   localparam logic [13:0] YEAR_MIN = 14'd1000;
   localparam logic [13:0] YEAR_MAX = 14'd9998;
   localparam logic [3:0]  MONTH_DEC = 4'd12;
   localparam logic [13:0] CENT_SIZE = 14'd100;
   // 5243 / 2^19 gives year / 100 exactly for every 14-bit year
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam logic [6:0]  CENT_LAST = 7'd99;
   localparam logic        SPLIT_TOP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SPLIT,
      ST_CHECK,
      ST_LOOP,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic split;
      logic check;
      logic step;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       split_last;
      logic       date_ok;
      logic [1:0] op;
      logic       loop_end;
      logic       step_ovf;
   } sts_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      begin
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

>>> rtl/core/date_add_with_validation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date add with validation
// Validates a Gregorian date and adds days, weeks or years to it.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats carry a start date and an amount; req_tuser selects the
//   unit (days, weeks, years). One response beat per request carries the new
//   date and a status in rsp_tuser: ok, invalid input date or year overflow.
//   On any error the date fields of the response are zero.
//   Steps: load, split of the year into century and year-in-century
//   (reciprocal multiply, then subtract), check, then for days and weeks
//   the month-stepping loop, one step per month crossed plus a final one,
//   then into the output register. A years add or an invalid date skips the
//   loop; the largest weeks amount crosses about 942 months. One request is
//   in work at a time. The next request is taken as soon as a result sits
//   in the output register, even while the receiver stalls; if a second
//   result is ready before the first is taken, the controller waits in its
//   final state. Reset returns the controller to idle and drops any
//   pending response.
// ----------------------------------------------------------------------------
module date_add_with_validation
   import dawv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [4:0] in_day, [8:5] in_month, [22:9] in_year, [34:23] amount, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] op
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [4:0] out_day, [8:5] out_month, [22:9] out_year, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [1:0]            rsp_tuser
);

   cmd_type     cmd;
   sts_type     sts;
   logic [4:0]  out_day;
   logic [3:0]  out_month;
   logic [13:0] out_year;

   dawv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dawv_dpath u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .sts        (sts),
      .in_op      (req_tuser),
      .in_day     (req_tdata[4:0]),
      .in_month   (req_tdata[8:5]),
      .in_year    (req_tdata[22:9]),
      .in_amount  (req_tdata[34:23]),
      .out_status (rsp_tuser),
      .out_day    (out_day),
      .out_month  (out_month),
      .out_year   (out_year)
   );

   assign rsp_tdata = {1'b0, out_year, out_month, out_day};

   // an accepted request keeps the input closed on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a previous one is in work");

   // errors return an all-zero date
   a_error_zero_date: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STAT_OK |-> rsp_tdata == '0)
      else $error("error response with non-zero date");

   // a good result is always a real calendar month within range
   a_ok_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_OK |->
         out_month >= 4'd1 && out_month <= MONTH_DEC && out_year >= YEAR_MIN &&
         out_year <= YEAR_MAX && out_day != 5'd0)
      else $error("ok response outside calendar range");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response beat changed while stalled");

endmodule

>>> rtl/core/dawv_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder datapath
// Holds the working date, splits the year into century and year-in-century,
// validates, adds years, and rolls days forward one month per step.
// ----------------------------------------------------------------------------
module dawv_dpath
   import dawv_pkg::*;
(
   input  logic                  clock,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic [1:0]            in_op,
   input  logic [4:0]            in_day,
   input  logic [3:0]            in_month,
   input  logic [13:0]           in_year,
   input  logic [11:0]           in_amount,
   output logic [1:0]            out_status,
   output logic [4:0]            out_day,
   output logic [3:0]            out_month,
   output logic [13:0]           out_year
);

   logic [1:0]  op_ff,      op_in;
   logic [4:0]  day_ff,     day_in;
   logic [3:0]  mon_ff,     mon_in;
   logic [13:0] year_ff,    year_in;
   logic [11:0] amt_ff,     amt_in;
   logic [14:0] rest_ff,    rest_in;
   logic [7:0]  cent_ff,    cent_in;
   logic [13:0] yrem_ff,    yrem_in;
   logic        split_cnt_ff, split_cnt_in;
   logic [1:0]  status_ff,  status_in;

   logic [1:0]  o_status_ff, o_status_in;
   logic [4:0]  o_day_ff,    o_day_in;
   logic [3:0]  o_mon_ff,    o_mon_in;
   logic [13:0] o_year_ff,   o_year_in;

   logic [26:0] recip_prod;
   logic [13:0] cent_x100;
   logic        leap;
   logic [4:0]  len;
   logic        date_ok;
   logic [14:0] year_sum;
   logic [15:0] day_sum;
   logic        loop_end;
   logic [14:0] rest_load;

   assign recip_prod = {13'd0, yrem_ff} * {14'd0, RECIP_100};
   assign cent_x100  = {6'd0, cent_ff} * CENT_SIZE;

   assign leap = (yrem_ff[6:0] == 7'd0) ? (cent_ff[1:0] == 2'd0) : (yrem_ff[1:0] == 2'd0);
   assign len  = month_len(mon_ff, leap);

   assign date_ok = (year_ff >= YEAR_MIN) && (year_ff <= YEAR_MAX) &&
                    (mon_ff >= 4'd1) && (mon_ff <= MONTH_DEC) &&
                    (day_ff >= 5'd1) && (day_ff <= len);

   assign year_sum  = {1'b0, year_ff} + {3'b000, amt_ff};
   assign day_sum   = {11'd0, day_ff} + {1'b0, rest_ff};
   assign loop_end  = day_sum <= {11'd0, len};
   assign rest_load = (in_op == OP_WEEKS) ? ({in_amount, 3'b000} - {3'b000, in_amount})
                                          : {3'b000, in_amount};

   assign sts.split_last = split_cnt_ff == 1'b0;
   assign sts.date_ok    = date_ok;
   assign sts.op         = op_ff;
   assign sts.loop_end   = loop_end;
   assign sts.step_ovf   = !loop_end && (mon_ff == MONTH_DEC) && (year_ff == YEAR_MAX);

   always_comb begin
      op_in        = op_ff;
      day_in       = day_ff;
      mon_in       = mon_ff;
      year_in      = year_ff;
      amt_in       = amt_ff;
      rest_in      = rest_ff;
      cent_in      = cent_ff;
      yrem_in      = yrem_ff;
      split_cnt_in = split_cnt_ff;
      status_in    = status_ff;
      o_status_in  = o_status_ff;
      o_day_in     = o_day_ff;
      o_mon_in     = o_mon_ff;
      o_year_in    = o_year_ff;

      if (cmd.load) begin
         op_in        = in_op;
         day_in       = in_day;
         mon_in       = in_month;
         year_in      = in_year;
         amt_in       = in_amount;
         rest_in      = rest_load;
         cent_in      = 8'd0;
         yrem_in      = in_year;
         split_cnt_in = SPLIT_TOP;
         status_in    = STAT_OK;
      end

      // century by reciprocal first, then strip it off to leave year-in-century
      if (cmd.split) begin
         if (split_cnt_ff == 1'b1) begin
            cent_in = recip_prod[26:19];
         end else begin
            yrem_in = yrem_ff - cent_x100;
         end
         split_cnt_in = split_cnt_ff - 1'b1;
      end

      if (cmd.check) begin
         if (!date_ok) begin
            status_in = STAT_BAD_DATE;
         end else if (op_ff == OP_YEARS) begin
            if (year_sum > {1'b0, YEAR_MAX}) begin
               status_in = STAT_OVERFLOW;
            end else begin
               year_in = year_sum[13:0];
            end
         end
      end

      // advance one month, or finish inside the current one
      if (cmd.step) begin
         if (loop_end) begin
            day_in = day_sum[4:0];
         end else begin
            rest_in = rest_ff - {10'd0, len - day_ff};
            day_in  = 5'd0;
            if (mon_ff == MONTH_DEC) begin
               mon_in = 4'd1;
               if (year_ff == YEAR_MAX) begin
                  status_in = STAT_OVERFLOW;
               end else begin
                  year_in = year_ff + 14'd1;
                  if (yrem_ff[6:0] == CENT_LAST) begin
                     yrem_in = 14'd0;
                     cent_in = cent_ff + 8'd1;
                  end else begin
                     yrem_in = yrem_ff + 14'd1;
                  end
               end
            end else begin
               mon_in = mon_ff + 4'd1;
            end
         end
      end

      if (cmd.emit) begin
         o_status_in = status_ff;
         if (status_ff == STAT_OK) begin
            o_day_in  = day_ff;
            o_mon_in  = mon_ff;
            o_year_in = year_ff;
         end else begin
            o_day_in  = 5'd0;
            o_mon_in  = 4'd0;
            o_year_in = 14'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      day_ff       <= day_in;
      mon_ff       <= mon_in;
      year_ff      <= year_in;
      amt_ff       <= amt_in;
      rest_ff      <= rest_in;
      cent_ff      <= cent_in;
      yrem_ff      <= yrem_in;
      split_cnt_ff <= split_cnt_in;
      status_ff    <= status_in;
      o_status_ff  <= o_status_in;
      o_day_ff     <= o_day_in;
      o_mon_ff     <= o_mon_in;
      o_year_ff    <= o_year_in;
   end

   assign out_status = o_status_ff;
   assign out_day    = o_day_ff;
   assign out_month  = o_mon_ff;
   assign out_year   = o_year_ff;

endmodule

>>> rtl/core/dawv_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder controller
// Sequences load, year split, validation and the month loop, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module dawv_ctrl
   import dawv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            cmd.split = 1'b1;
            if (sts.split_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (sts.date_ok && (sts.op == OP_DAYS || sts.op == OP_WEEKS)) begin
               state_in = ST_LOOP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOOP: begin
            cmd.step = 1'b1;
            if (sts.loop_end || sts.step_ovf) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register can take the beat
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> tb/tb_date_add_with_validation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder testbench
// Drives dated requests through the stream ports and checks every response
// against typed-in values or a local calendar predictor: directed edge cases
// first, then weighted random requests, with random idling on both sides and
// one long receiver hold-off that backs the block up into its request port.
// ----------------------------------------------------------------------------
module tb_date_add_with_validation;
   import dawv_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 10;
   localparam int RANDOM_ITEMS = 515;
   localparam int IDLE_PCT     = 32;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 2500;
   localparam int DRAIN_CYCLES = 1100;
   localparam int LIMIT_CYCLES = 3_000_000;
   localparam int STEADY_FIRST = 300;
   localparam int STEADY_LAST  = 380;

   // unit code the block leaves unused: date is only validated
   localparam logic [1:0] OP_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [11:0] amount;
   } date_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
   } date_rsp_type;

   typedef struct packed {
      date_req_type req;
      logic         typed;
      date_rsp_type want;
   } date_case_type;

   localparam date_rsp_type BLANK = '0;
   localparam date_rsp_type BAD   = '{STAT_BAD_DATE, 5'd0, 4'd0, 14'd0};
   localparam date_rsp_type OVF   = '{STAT_OVERFLOW, 5'd0, 4'd0, 14'd0};

   localparam date_case_type DIRECTED [27] = '{
      '{'{OP_DAYS,  5'd1,  4'd1,  14'd1000,  12'd0},    1'b1, '{STAT_OK, 5'd1, 4'd1, 14'd1000}},
      '{'{OP_YEARS, 5'd31, 4'd12, 14'd9998,  12'd0},    1'b1,
         '{STAT_OK, 5'd31, 4'd12, 14'd9998}},
      '{'{OP_DAYS,  5'd31, 4'd12, 14'd9998,  12'd1},    1'b1, OVF},
      '{'{OP_DAYS,  5'd0,  4'd1,  14'd2000,  12'd5},    1'b1, BAD},
      '{'{OP_DAYS,  5'd31, 4'd4,  14'd2000,  12'd1},    1'b1, BAD},
      '{'{OP_WEEKS, 5'd1,  4'd0,  14'd2000,  12'd1},    1'b1, BAD},
      '{'{OP_WEEKS, 5'd1,  4'd13, 14'd2000,  12'd3},    1'b1, BAD},
      '{'{OP_DAYS,  5'd1,  4'd15, 14'd2000,  12'd1},    1'b1, BAD},
      '{'{OP_YEARS, 5'd1,  4'd1,  14'd999,   12'd1},    1'b1, BAD},
      '{'{OP_YEARS, 5'd1,  4'd1,  14'd9999,  12'd0},    1'b1, BAD},
      '{'{OP_DAYS,  5'd29, 4'd2,  14'd2000,  12'd0},    1'b1, '{STAT_OK, 5'd29, 4'd2, 14'd2000}},
      '{'{OP_DAYS,  5'd29, 4'd2,  14'd1900,  12'd0},    1'b1, BAD},
      '{'{OP_DAYS,  5'd29, 4'd2,  14'd2004,  12'd0},    1'b1, '{STAT_OK, 5'd29, 4'd2, 14'd2004}},
      '{'{OP_DAYS,  5'd29, 4'd2,  14'd2003,  12'd0},    1'b1, BAD},
      '{'{OP_YEARS, 5'd29, 4'd2,  14'd2000,  12'd1},    1'b1, '{STAT_OK, 5'd29, 4'd2, 14'd2001}},
      '{'{OP_YEARS, 5'd15, 4'd6,  14'd5903,  12'd4095}, 1'b1, '{STAT_OK, 5'd15, 4'd6, 14'd9998}},
      '{'{OP_YEARS, 5'd15, 4'd6,  14'd5904,  12'd4095}, 1'b1, OVF},
      '{'{OP_NONE,  5'd15, 4'd7,  14'd2024,  12'd4095}, 1'b1, '{STAT_OK, 5'd15, 4'd7, 14'd2024}},
      '{'{OP_NONE,  5'd30, 4'd2,  14'd2024,  12'd1},    1'b1, BAD},
      '{'{OP_NONE,  5'd31, 4'd15, 14'd16383, 12'd4095}, 1'b1, BAD},
      '{'{OP_DAYS,  5'd0,  4'd0,  14'd0,     12'd0},    1'b1, BAD},
      '{'{OP_DAYS,  5'd31, 4'd1,  14'd2023,  12'd1},    1'b0, BLANK},
      '{'{OP_DAYS,  5'd28, 4'd2,  14'd2023,  12'd1},    1'b0, BLANK},
      '{'{OP_WEEKS, 5'd31, 4'd12, 14'd1999,  12'd1},    1'b0, BLANK},
      '{'{OP_WEEKS, 5'd1,  4'd1,  14'd1000,  12'd4095}, 1'b0, BLANK},
      '{'{OP_DAYS,  5'd1,  4'd1,  14'd9998,  12'd4095}, 1'b0, BLANK},
      '{'{OP_WEEKS, 5'd28, 4'd2,  14'd2100,  12'd1},    1'b0, BLANK}
   };

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [1:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   date_rsp_type pending_rsp [$];
   int           mismatches = 0;
   bit           steady     = 1'b0;

   date_add_with_validation u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #(CLK_HALF) clock = ~clock;

   function automatic bit is_leap(input int unsigned y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return y % 4 == 0;
   endfunction

   function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   // Roll the date forward a month at a time; years add straight on.
   function automatic date_rsp_type add_date(input date_req_type r);
      date_rsp_type res;
      int unsigned  d, m, y, rest, len;
      d = r.day;
      m = r.month;
      y = r.year;
      res.status = STAT_OK;
      if (y < YEAR_MIN || y > YEAR_MAX || m < 1 || m > 12 || d < 1 || d > month_days(m, y)) begin
         res.status = STAT_BAD_DATE;
      end else if (r.op == OP_YEARS) begin
         y = y + r.amount;
         if (y > YEAR_MAX) res.status = STAT_OVERFLOW;
      end else if (r.op == OP_DAYS || r.op == OP_WEEKS) begin
         rest = (r.op == OP_WEEKS) ? 7 * r.amount : r.amount;
         len  = month_days(m, y);
         while (d + rest > len) begin
            rest = rest - (len - d);
            d    = 0;
            m    = m + 1;
            if (m > 12) begin
               m = 1;
               y = y + 1;
               if (y > YEAR_MAX) begin
                  res.status = STAT_OVERFLOW;
                  break;
               end
            end
            len = month_days(m, y);
         end
         d = d + rest;
      end
      if (res.status != STAT_OK) begin
         d = 0;
         m = 0;
         y = 0;
      end
      res.day   = 5'(d);
      res.month = 4'(m);
      res.year  = 14'(y);
      return res;
   endfunction

   function automatic logic [13:0] pick_year();
      case ($urandom_range(9))
         0:       return 14'($urandom_range(9998, 9975));
         1:       return 14'($urandom_range(1010, 1000));
         2: begin
            case ($urandom_range(5))
               0:       return 14'd1600;
               1:       return 14'd1700;
               2:       return 14'd2000;
               3:       return 14'd2100;
               4:       return 14'd9600;
               default: return 14'd9900;
            endcase
         end
         3:       return 14'($urandom_range(2030, 1995));
         default: return 14'($urandom_range(9998, 1000));
      endcase
   endfunction

   // Mostly well-formed requests with small amounts; a slice of raw noise.
   function automatic date_req_type random_item();
      date_req_type r;
      int unsigned  len, roll;
      r.op = ($urandom_range(99) < 6) ? OP_NONE : 2'($urandom_range(2));
      if ($urandom_range(99) < 12) begin
         r.day   = 5'($urandom);
         r.month = 4'($urandom);
         r.year  = 14'($urandom);
      end else begin
         r.year  = pick_year();
         r.month = 4'($urandom_range(12, 1));
         len     = month_days(r.month, r.year);
         roll    = $urandom_range(99);
         if (roll < 20)      r.day = 5'(len);
         else if (roll < 27) r.day = 5'(len + 1);
         else                r.day = 5'($urandom_range(len, 1));
      end
      roll = $urandom_range(99);
      if (r.op == OP_YEARS)
         r.amount = (roll < 50) ? 12'($urandom_range(4095)) : 12'($urandom_range(15));
      else if (roll < 80)
         r.amount = 12'($urandom_range(63));
      else if (roll < 92)
         r.amount = 12'($urandom_range(400));
      else
         r.amount = 12'($urandom_range(4095));
      return r;
   endfunction

   task automatic flag_error(input string what, input int got, input int want);
      $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   // Offer one beat; valid stays high from the previous beat unless we idle.
   task automatic offer_date(input date_req_type r, input date_rsp_type want);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, r.amount, r.year, r.month, r.day};
      req_tuser  <= r.op;
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(want);
   endtask

   initial begin : req_side
      date_req_type r;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED[i]) begin
         r = DIRECTED[i].req;
         offer_date(r, DIRECTED[i].typed ? DIRECTED[i].want : add_date(r));
      end
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= STEADY_FIRST && i < STEADY_LAST);
         r = random_item();
         offer_date(r, add_date(r));
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off so the block backs up.
   initial begin : rsp_side
      int unsigned taken, stall_left;
      taken      = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            taken++;
            if (taken == HOLD_AT) stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      date_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            flag_error("response beat with nothing outstanding, status", rsp_tuser, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tuser != want.status)
               flag_error("status", rsp_tuser, want.status);
            if (rsp_tdata[4:0] != want.day)
               flag_error("out_day", rsp_tdata[4:0], want.day);
            if (rsp_tdata[8:5] != want.month)
               flag_error("out_month", rsp_tdata[8:5], want.month);
            if (rsp_tdata[22:9] != want.year)
               flag_error("out_year", rsp_tdata[22:9], want.year);
         end
      end
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/dawv_pkg.sv
rtl/core/dawv_dpath.sv
rtl/core/dawv_ctrl.sv
rtl/core/date_add_with_validation.sv
tb/tb_date_add_with_validation.sv
